[rtl/bfua_pkg.sv]
`default_nettype none

package bfua_pkg;

    // store geometry
    localparam int MEM_UNITS  = 8;
    localparam int UNIT_BYTES = 50;

    // widths
    localparam int IDX_W  = $clog2(MEM_UNITS);
    localparam int CNT_W  = $clog2(MEM_UNITS + 1);
    localparam int LEN_W  = $clog2(MEM_UNITS + 3);
    localparam int SUM_W  = LEN_W + 1;
    localparam int OUT_W  = 3;
    localparam int ID_W   = 8;
    localparam int SIZE_W = 12;
    localparam int ST_W   = 3;

    // register port
    localparam int APB_DW    = 32;
    localparam int APB_AW    = 3;
    localparam int REG_IDX_W = APB_AW - 2;
    localparam logic [REG_IDX_W-1:0] REG_EXTRA = '0;

    // request kinds
    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    // result codes
    localparam logic [ST_W-1:0] ST_ALLOC    = 3'd0;
    localparam logic [ST_W-1:0] ST_NOFIT    = 3'd1;
    localparam logic [ST_W-1:0] ST_FREED    = 3'd2;
    localparam logic [ST_W-1:0] ST_NOTFOUND = 3'd3;
    localparam logic [ST_W-1:0] ST_ZERO     = 3'd4;

    typedef struct packed {
        logic              req_type;
        logic [ID_W-1:0]   prog_id;
        logic [SIZE_W-1:0] size_bytes;
    } req_t;

    typedef struct packed {
        logic [ST_W-1:0]  status;
        logic [OUT_W-1:0] start_unit;
        logic [OUT_W-1:0] end_unit;
    } rsp_t;

    // controller to datapath
    typedef struct packed {
        logic load_req;
        logic alloc_step;
        logic commit;
        logic find_step;
        logic clear_step;
        logic load_out;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic free_req;
        logic zero_size;
        logic scan_done;
        logic find_last;
        logic hit;
        logic clear_stop;
    } sts_t;

endpackage

`default_nettype wire

[rtl/best_fit_unit_allocator.sv]
// allocate: 9 scan steps over the unit map, one commit, then one output load
//   once the output register is free; no new request is taken meanwhile
// free: owner search, then release of the rest of the partition, then output load
// zero size: no scan; the result goes straight to the output load
// reset: all units free, extra margin register at 1, no result pending
`default_nettype none

module best_fit_unit_allocator
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           req_valid,
    output logic                                req_ready,
    input  wire bfua_pkg::req_t                 req,
    output logic                                rsp_valid,
    input  wire logic                           rsp_ready,
    output bfua_pkg::rsp_t                      rsp,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [bfua_pkg::APB_AW-1:0]    paddr,
    input  wire logic [bfua_pkg::APB_DW-1:0]    pwdata,
    output logic [bfua_pkg::APB_DW-1:0]         prdata,
    output logic                                pready
);
    import bfua_pkg::*;

    logic extra_reg;
    logic reg_hit;
    cmd_t cmd;
    sts_t sts;

    // configuration register
    assign pready  = 1'b1;
    assign reg_hit = paddr[APB_AW-1:2] == REG_EXTRA;
    assign prdata  = reg_hit ? {{(APB_DW-1){1'b0}}, extra_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            extra_reg <= 1'b1;
        end
        else if (psel && penable && pwrite && pready && reg_hit)
        begin
            extra_reg <= pwdata[0];
        end
    end

    bfua_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    bfua_datapath u_datapath
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .cmd   (cmd),
        .extra (extra_reg),
        .sts   (sts),
        .rsp   (rsp)
    );

endmodule

`default_nettype wire

[rtl/bfua_datapath.sv]
`default_nettype none

module bfua_datapath
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire bfua_pkg::req_t req,
    input  wire bfua_pkg::cmd_t cmd,
    input  wire logic          extra,
    output bfua_pkg::sts_t     sts,
    output bfua_pkg::rsp_t     rsp
);
    import bfua_pkg::*;

    // unit map
    logic [MEM_UNITS-1:0] used_reg, used_next;
    logic [MEM_UNITS-1:0] start_reg, start_next;
    logic [ID_W-1:0]      owner_reg [MEM_UNITS];
    logic [ID_W-1:0]      owner_next [MEM_UNITS];

    // request and scan registers
    logic [ID_W-1:0]  id_reg;
    logic [LEN_W-1:0] units_reg;
    logic [LEN_W-1:0] need_reg;
    logic [CNT_W-1:0] idx_reg;
    logic [IDX_W-1:0] run_start_reg;
    logic [LEN_W-1:0] run_len_reg;
    logic [IDX_W-1:0] best_start_reg;
    logic [LEN_W-1:0] best_len_reg;
    logic             found_reg;
    logic [IDX_W-1:0] part_start_reg;
    rsp_t             res_reg;
    rsp_t             rsp_reg;

    logic [LEN_W-1:0] units_calc;
    logic [LEN_W-1:0] need_calc;
    logic [IDX_W-1:0] idx_lo;
    logic             in_mem;
    logic             cur_used;
    logic             cur_start;
    logic [ID_W-1:0]  cur_owner;
    logic             hit;
    logic             run_ok;
    logic [SUM_W-1:0] alloc_lim;
    logic [SUM_W-1:0] alloc_end;
    logic             clear_here;

    // size rounded up to units, saturated past the store size
    always_comb
    begin
        units_calc = '0;
        for (int k = 0; k < MEM_UNITS; k++)
        begin
            if (int'(req.size_bytes) > k * UNIT_BYTES)
            begin
                units_calc = LEN_W'(units_calc + 1'b1);
            end
        end
        if (int'(req.size_bytes) > MEM_UNITS * UNIT_BYTES)
        begin
            units_calc = LEN_W'(MEM_UNITS + 1);
        end
    end

    assign need_calc = LEN_W'(units_calc + LEN_W'(extra));

    // current unit lookup
    assign idx_lo    = idx_reg[IDX_W-1:0];
    assign in_mem    = idx_reg < CNT_W'(MEM_UNITS);
    assign cur_used  = in_mem && used_reg[idx_lo];
    assign cur_start = in_mem && start_reg[idx_lo];
    assign cur_owner = owner_reg[idx_lo];
    assign hit       = cur_used && cur_start && (cur_owner == id_reg);

    // a free run closes here and beats the best so far
    assign run_ok = (run_len_reg != '0) && (run_len_reg >= need_reg)
                    && (run_len_reg < best_len_reg);

    assign alloc_lim  = SUM_W'(best_start_reg) + SUM_W'(units_reg);
    assign alloc_end  = SUM_W'(alloc_lim - 1'b1);
    assign clear_here = (cmd.find_step && hit) || (cmd.clear_step && !sts.clear_stop);

    // status to controller
    always_comb
    begin
        sts.free_req   = req.req_type == REQ_FREE;
        sts.zero_size  = req.size_bytes == '0;
        sts.scan_done  = idx_reg == CNT_W'(MEM_UNITS);
        sts.find_last  = idx_reg == CNT_W'(MEM_UNITS - 1);
        sts.hit        = hit;
        sts.clear_stop = !(cur_used && !cur_start);
    end

    // unit map updates
    always_comb
    begin
        used_next  = used_reg;
        start_next = start_reg;
        owner_next = owner_reg;
        if (cmd.commit && found_reg)
        begin
            for (int u = 0; u < MEM_UNITS; u++)
            begin
                if (SUM_W'(u) >= SUM_W'(best_start_reg) && SUM_W'(u) < alloc_lim)
                begin
                    used_next[u]  = 1'b1;
                    start_next[u] = SUM_W'(u) == SUM_W'(best_start_reg);
                    owner_next[u] = id_reg;
                end
            end
        end
        if (clear_here)
        begin
            used_next[idx_lo]  = 1'b0;
            start_next[idx_lo] = 1'b0;
            owner_next[idx_lo] = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg       <= '0;
            start_reg      <= '0;
            for (int u = 0; u < MEM_UNITS; u++)
            begin
                owner_reg[u] <= '0;
            end
            id_reg         <= '0;
            units_reg      <= '0;
            need_reg       <= '0;
            idx_reg        <= '0;
            run_start_reg  <= '0;
            run_len_reg    <= '0;
            best_start_reg <= '0;
            best_len_reg   <= LEN_W'(MEM_UNITS + 1);
            found_reg      <= 1'b0;
            part_start_reg <= '0;
            res_reg        <= '0;
            rsp_reg        <= '0;
        end
        else
        begin
            used_reg  <= used_next;
            start_reg <= start_next;
            owner_reg <= owner_next;

            // latch request, reset scan
            if (cmd.load_req)
            begin
                id_reg         <= req.prog_id;
                units_reg      <= units_calc;
                need_reg       <= need_calc;
                idx_reg        <= '0;
                run_len_reg    <= '0;
                best_start_reg <= '0;
                best_len_reg   <= LEN_W'(MEM_UNITS + 1);
                found_reg      <= 1'b0;
                res_reg        <= '{status: ST_ZERO, start_unit: '0, end_unit: '0};
            end
            // best-fit scan, one unit a cycle plus a closing step
            else if (cmd.alloc_step)
            begin
                idx_reg <= CNT_W'(idx_reg + 1'b1);
                if (in_mem && !cur_used)
                begin
                    if (run_len_reg == '0)
                    begin
                        run_start_reg <= idx_lo;
                    end
                    run_len_reg <= LEN_W'(run_len_reg + 1'b1);
                end
                else
                begin
                    if (run_ok)
                    begin
                        best_len_reg   <= run_len_reg;
                        best_start_reg <= run_start_reg;
                        found_reg      <= 1'b1;
                    end
                    run_len_reg <= '0;
                end
            end
            else if (cmd.commit)
            begin
                if (found_reg)
                begin
                    res_reg <= '{status: ST_ALLOC,
                                 start_unit: OUT_W'(best_start_reg),
                                 end_unit: OUT_W'(alloc_end)};
                end
                else
                begin
                    res_reg <= '{status: ST_NOFIT, start_unit: '0, end_unit: '0};
                end
            end
            // owner search
            else if (cmd.find_step)
            begin
                idx_reg <= CNT_W'(idx_reg + 1'b1);
                if (hit)
                begin
                    part_start_reg <= idx_lo;
                end
                else if (sts.find_last)
                begin
                    res_reg <= '{status: ST_NOTFOUND, start_unit: '0, end_unit: '0};
                end
            end
            // release the rest of the partition
            else if (cmd.clear_step)
            begin
                if (!sts.clear_stop)
                begin
                    idx_reg <= CNT_W'(idx_reg + 1'b1);
                end
                else
                begin
                    res_reg <= '{status: ST_FREED,
                                 start_unit: OUT_W'(part_start_reg),
                                 end_unit: OUT_W'(CNT_W'(idx_reg - 1'b1))};
                end
            end
            else if (cmd.load_out)
            begin
                rsp_reg <= res_reg;
            end
        end
    end

    assign rsp = rsp_reg;

`ifndef ASSERT_OFF
    a_start_implies_used: assert property (@(posedge clk) disable iff (!rst_n)
        (start_reg & ~used_reg) == '0)
        else $error("partition start on a free unit");

    a_best_fits: assert property (@(posedge clk) disable iff (!rst_n)
        found_reg |-> best_len_reg >= need_reg)
        else $error("chosen run shorter than needed");

    a_commit_marks_start: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && found_reg) |=>
            (used_reg[$past(best_start_reg)] && start_reg[$past(best_start_reg)]))
        else $error("allocation did not mark its first unit");
`endif

endmodule

`default_nettype wire

[rtl/bfua_ctrl.sv]
`default_nettype none

module bfua_ctrl
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           req_valid,
    output logic                req_ready,
    output logic                rsp_valid,
    input  wire logic           rsp_ready,
    input  wire bfua_pkg::sts_t sts,
    output bfua_pkg::cmd_t      cmd
);
    import bfua_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ALLOC,
        S_COMMIT,
        S_FIND,
        S_CLEAR,
        S_RESP
    } state_t;

    state_t state_reg, state_next;
    logic   rsp_valid_reg, rsp_valid_next;

    assign req_ready = state_reg == S_IDLE;
    assign rsp_valid = rsp_valid_reg;

    // sequencing and commands
    always_comb
    begin
        state_next     = state_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        cmd            = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load_req = 1'b1;
                    if (sts.free_req)
                    begin
                        state_next = S_FIND;
                    end
                    else if (sts.zero_size)
                    begin
                        state_next = S_RESP;
                    end
                    else
                    begin
                        state_next = S_ALLOC;
                    end
                end
            end
            S_ALLOC:
            begin
                cmd.alloc_step = 1'b1;
                if (sts.scan_done)
                begin
                    state_next = S_COMMIT;
                end
            end
            S_COMMIT:
            begin
                cmd.commit = 1'b1;
                state_next = S_RESP;
            end
            S_FIND:
            begin
                cmd.find_step = 1'b1;
                if (sts.hit)
                begin
                    state_next = S_CLEAR;
                end
                else if (sts.find_last)
                begin
                    state_next = S_RESP;
                end
            end
            S_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (sts.clear_stop)
                begin
                    state_next = S_RESP;
                end
            end
            S_RESP:
            begin
                // hand over once the output register is free
                if (!rsp_valid_reg || rsp_ready)
                begin
                    cmd.load_out   = 1'b1;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

`ifndef ASSERT_OFF
    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load_req, cmd.alloc_step, cmd.commit,
                  cmd.find_step, cmd.clear_step, cmd.load_out}))
        else $error("more than one datapath command");

    a_load_out_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |=> rsp_valid_reg)
        else $error("result loaded without valid");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> !req_ready)
        else $error("second request taken while busy");
`endif

endmodule

`default_nettype wire

[tb/sv/best_fit_unit_allocator_tb.sv]
module best_fit_unit_allocator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bfua_pkg::*;

    // run shape
    localparam int PHASES       = 6;
    localparam int PHASE_ITEMS  = 300;
    localparam int HOLD_AT      = 400;
    localparam int HOLD_CYCLES  = 400;
    localparam int QUIET_LO     = 1000;
    localparam int QUIET_HI     = 1300;
    localparam int NO_WRITE     = -1;
    localparam int FROM_MAP     = -1;

    logic                clk;
    logic                rst_n;
    logic                req_valid;
    logic                req_ready;
    req_t                req;
    logic                rsp_valid;
    logic                rsp_ready;
    rsp_t                rsp;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [APB_AW-1:0]   paddr;
    logic [APB_DW-1:0]   pwdata;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    // shadow copy of the unit map and the margin register
    logic                used_map  [MEM_UNITS];
    logic [ID_W-1:0]     owner_map [MEM_UNITS];
    logic                head_map  [MEM_UNITS];
    logic                margin;

    // replies owed by the block, oldest first
    rsp_t                pending_replies [$];
    int                  reqs_taken;
    int                  error_count;

    // fixed reply for the beat on the request port, when the row gives one
    logic                fixed_valid;
    rsp_t                fixed_reply;

    typedef struct {
        int   margin_set;
        req_t beat;
        bit   fixed;
        rsp_t reply;
    } dir_row_t;

    dir_row_t            dir_rows [$];

    best_fit_unit_allocator u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // run limit
    initial
    begin
        #6_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // stretch of the random part with no idling on either side
    function automatic bit quiet();
        return reqs_taken >= QUIET_LO && reqs_taken < QUIET_HI;
    endfunction

    // best-fit grant or partition release on the shadow map
    function automatic rsp_t compute_reply(input req_t r);
        rsp_t o;
        int   units;
        int   need;
        int   best_start;
        int   best_len;
        int   run_start;
        int   run_len;
        int   i;
        int   j;
        bit   hit;
        o   = '0;
        hit = 1'b0;
        if (r.req_type == REQ_ALLOC)
        begin
            if (r.size_bytes == '0)
            begin
                o.status = ST_ZERO;
            end
            else
            begin
                units      = (int'(r.size_bytes) + UNIT_BYTES - 1) / UNIT_BYTES;
                need       = units + int'(margin);
                best_start = 0;
                best_len   = MEM_UNITS + 1;
                run_start  = 0;
                run_len    = 0;
                // a run closes at a used unit or at the end of the map
                for (i = 0; i <= MEM_UNITS; i++)
                begin
                    if (i < MEM_UNITS && !used_map[i])
                    begin
                        if (run_len == 0)
                            run_start = i;
                        run_len++;
                    end
                    else
                    begin
                        if (run_len > 0 && run_len >= need && run_len < best_len)
                        begin
                            best_len   = run_len;
                            best_start = run_start;
                            hit        = 1'b1;
                        end
                        run_len = 0;
                    end
                end
                if (!hit)
                begin
                    o.status = ST_NOFIT;
                end
                else
                begin
                    // take the head of the run, the tail stays free
                    for (i = 0; i < units; i++)
                    begin
                        used_map[best_start + i]  = 1'b1;
                        owner_map[best_start + i] = r.prog_id;
                        head_map[best_start + i]  = (i == 0);
                    end
                    o.status     = ST_ALLOC;
                    o.start_unit = OUT_W'(best_start);
                    o.end_unit   = OUT_W'(best_start + units - 1);
                end
            end
        end
        else
        begin
            // lowest partition of this owner, up to the next head or free unit
            for (i = 0; i < MEM_UNITS && !hit; i++)
            begin
                if (used_map[i] && head_map[i] && owner_map[i] == r.prog_id)
                begin
                    hit = 1'b1;
                    j   = i;
                    do
                    begin
                        used_map[j]  = 1'b0;
                        owner_map[j] = '0;
                        head_map[j]  = 1'b0;
                        j++;
                    end
                    while (j < MEM_UNITS && used_map[j] && !head_map[j]);
                    o.status     = ST_FREED;
                    o.start_unit = OUT_W'(i);
                    o.end_unit   = OUT_W'(j - 1);
                end
            end
            if (!hit)
                o.status = ST_NOTFOUND;
        end
        return o;
    endfunction

    // random request, frees aimed mostly at ids that own a partition
    function automatic req_t random_req();
        req_t r;
        int   owners [$];
        int   roll;
        int   i;
        roll         = $urandom_range(0, 99);
        r.req_type   = (roll < 55) ? REQ_ALLOC : REQ_FREE;
        r.size_bytes = SIZE_W'($urandom_range(0, 4095));
        roll         = $urandom_range(0, 99);
        if (r.req_type == REQ_ALLOC)
        begin
            if (roll < 70)
                r.prog_id = ID_W'($urandom_range(1, 6));
            else
                r.prog_id = ID_W'($urandom_range(0, 255));
            roll = $urandom_range(0, 99);
            if (roll < 3)
                r.size_bytes = '0;
            else if (roll < 8)
                r.size_bytes = SIZE_W'($urandom_range(1, 4095));
            else if (roll < 70)
                r.size_bytes = SIZE_W'($urandom_range(1, 3 * UNIT_BYTES));
            else
                r.size_bytes = SIZE_W'($urandom_range(1, MEM_UNITS * UNIT_BYTES));
        end
        else
        begin
            for (i = 0; i < MEM_UNITS; i++)
            begin
                if (used_map[i] && head_map[i])
                    owners.push_back(i);
            end
            if (roll < 75 && owners.size() > 0)
                r.prog_id = owner_map[owners[$urandom_range(0, owners.size() - 1)]];
            else if (roll < 90)
                r.prog_id = ID_W'($urandom_range(1, 6));
            else
                r.prog_id = ID_W'($urandom_range(0, 255));
        end
        return r;
    endfunction

    // directed row; a status of FROM_MAP leaves the reply to the shadow map
    task automatic add_row(input int margin_set, input logic kind, input int id,
                           input int bytes, input int st, input int first,
                           input int last);
        dir_row_t row;
        row.margin_set           = margin_set;
        row.beat.req_type        = kind;
        row.beat.prog_id         = ID_W'(id);
        row.beat.size_bytes      = SIZE_W'(bytes);
        row.fixed                = (st != FROM_MAP);
        row.reply.status         = ST_W'(st);
        row.reply.start_unit     = OUT_W'(first);
        row.reply.end_unit       = OUT_W'(last);
        dir_rows.push_back(row);
    endtask

    // one request beat, with a random gap ahead of it
    task automatic send_beat(input req_t r, input bit fixed, input rsp_t reply);
        while (!quiet() && $urandom_range(0, 99) < 12)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req         <= r;
        fixed_valid <= fixed;
        fixed_reply <= reply;
        req_valid   <= 1'b1;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // stop offering and wait for every owed reply
    task automatic drain();
        req_valid <= 1'b0;
        @(negedge clk);
        while (pending_replies.size() != 0)
            @(negedge clk);
    endtask

    // margin register write, then read back
    task automatic write_margin(input logic v);
        paddr   <= {REG_EXTRA, 2'b00};
        pwdata  <= APB_DW'(v);
        pwrite  <= 1'b1;
        psel    <= 1'b1;
        penable <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        margin = v;
        @(negedge clk);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata !== APB_DW'(v))
        begin
            $error("prdata: expected %0d, got %0d", APB_DW'(v), prdata);
            error_count++;
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // request and reply beats at the rising edge
    always @(posedge clk)
    begin : beat_check
        rsp_t want;
        rsp_t model;
        if (rst_n)
        begin
            if (req_valid && req_ready)
            begin
                model = compute_reply(req);
                pending_replies.push_back(fixed_valid ? fixed_reply : model);
                reqs_taken++;
            end
            if (rsp_valid && rsp_ready)
            begin
                if (pending_replies.size() == 0)
                begin
                    $error("reply beat with nothing owed: status %0d", rsp.status);
                    error_count++;
                end
                else
                begin
                    want = pending_replies.pop_front();
                    if (rsp.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, rsp.status);
                        error_count++;
                    end
                    if (rsp.start_unit !== want.start_unit)
                    begin
                        $error("start_unit: expected %0d, got %0d",
                               want.start_unit, rsp.start_unit);
                        error_count++;
                    end
                    if (rsp.end_unit !== want.end_unit)
                    begin
                        $error("end_unit: expected %0d, got %0d",
                               want.end_unit, rsp.end_unit);
                        error_count++;
                    end
                end
            end
        end
    end

    // reply side: random stalls plus one long hold-off
    initial
    begin : reply_sink
        bit held;
        held      = 1'b0;
        rsp_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (!held && reqs_taken >= HOLD_AT)
            begin
                // block backs up and stalls its request side meanwhile
                held = 1'b1;
                rsp_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            rsp_ready <= quiet() || ($urandom_range(0, 99) >= 12);
        end
    end

    // stimulus
    initial
    begin : stimulus
        dir_row_t row;
        int       k;
        int       p;
        req_valid   = 1'b0;
        req         = '0;
        fixed_valid = 1'b0;
        fixed_reply = '0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        reqs_taken  = 0;
        error_count = 0;
        margin      = 1'b1;
        for (k = 0; k < MEM_UNITS; k++)
        begin
            used_map[k]  = 1'b0;
            owner_map[k] = '0;
            head_map[k]  = 1'b0;
        end
        rst_n = 1'b0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // margin 1 out of reset, empty map
        add_row(NO_WRITE, REQ_ALLOC, 1, 0, ST_ZERO, 0, 0);
        add_row(NO_WRITE, REQ_FREE, 5, 0, ST_NOTFOUND, 0, 0);
        add_row(NO_WRITE, REQ_ALLOC, 1, 4095, ST_NOFIT, 0, 0);
        add_row(NO_WRITE, REQ_ALLOC, 1, 400, ST_NOFIT, 0, 0);
        add_row(NO_WRITE, REQ_ALLOC, 1, 350, ST_ALLOC, 0, 6);
        add_row(NO_WRITE, REQ_ALLOC, 2, 1, ST_NOFIT, 0, 0);
        add_row(NO_WRITE, REQ_FREE, 1, 4095, ST_FREED, 0, 6);
        add_row(NO_WRITE, REQ_ALLOC, 255, 1, ST_ALLOC, 0, 0);
        // id zero, two partitions under one id, unit rounding edges
        add_row(NO_WRITE, REQ_ALLOC, 0, 50, FROM_MAP, 0, 0);
        add_row(NO_WRITE, REQ_ALLOC, 128, 51, FROM_MAP, 0, 0);
        add_row(NO_WRITE, REQ_ALLOC, 255, 49, FROM_MAP, 0, 0);
        add_row(NO_WRITE, REQ_FREE, 255, 0, FROM_MAP, 0, 0);
        add_row(NO_WRITE, REQ_FREE, 0, 0, FROM_MAP, 0, 0);
        // margin 0: whole store fits, ties go to the lowest hole
        add_row(0, REQ_FREE, 128, 0, FROM_MAP, 0, 0);
        add_row(NO_WRITE, REQ_FREE, 255, 0, FROM_MAP, 0, 0);
        add_row(NO_WRITE, REQ_ALLOC, 3, 400, ST_ALLOC, 0, 7);
        add_row(NO_WRITE, REQ_ALLOC, 4, 1, ST_NOFIT, 0, 0);
        add_row(NO_WRITE, REQ_FREE, 3, 0, ST_FREED, 0, 7);
        add_row(NO_WRITE, REQ_ALLOC, 1, 50, FROM_MAP, 0, 0);
        add_row(NO_WRITE, REQ_ALLOC, 2, 100, FROM_MAP, 0, 0);
        add_row(NO_WRITE, REQ_ALLOC, 3, 50, FROM_MAP, 0, 0);
        add_row(NO_WRITE, REQ_ALLOC, 4, 150, FROM_MAP, 0, 0);
        add_row(NO_WRITE, REQ_FREE, 1, 0, FROM_MAP, 0, 0);
        add_row(NO_WRITE, REQ_ALLOC, 5, 50, FROM_MAP, 0, 0);
        add_row(NO_WRITE, REQ_FREE, 3, 0, FROM_MAP, 0, 0);
        add_row(NO_WRITE, REQ_ALLOC, 6, 1, FROM_MAP, 0, 0);

        // directed walk
        foreach (dir_rows[k])
        begin
            row = dir_rows[k];
            if (row.margin_set != NO_WRITE)
            begin
                drain();
                write_margin(row.margin_set[0]);
            end
            send_beat(row.beat, row.fixed, row.reply);
        end

        // random phases, margin rewritten between them
        for (p = 0; p < PHASES; p++)
        begin
            drain();
            if (p == 0)
                write_margin(1'b0);
            else if (p == 1)
                write_margin(1'b1);
            else
                write_margin(1'($urandom_range(0, 1)));
            repeat (PHASE_ITEMS) send_beat(random_req(), 1'b0, '0);
        end

        // settle and report
        drain();
        repeat (30) @(negedge clk);
        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

[best_fit_unit_allocator.f]
rtl/bfua_pkg.sv
rtl/bfua_datapath.sv
rtl/bfua_ctrl.sv
rtl/best_fit_unit_allocator.sv
tb/sv/best_fit_unit_allocator_tb.sv
